FILE: src/bptc_pkg.sv
// Shared types and constants for the barometric compensation block.
`default_nettype none
package bptc_pkg;
   localparam logic [1:0] CSR_TRIM_LOW  = 2'd0;
   localparam logic [1:0] CSR_TRIM_MID  = 2'd1;
   localparam logic [1:0] CSR_TRIM_HIGH = 2'd2;
   localparam logic [1:0] CSR_CAL       = 2'd3;

   localparam logic signed [23:0] TEMP_MAX = 24'sh7FFFFF;
   localparam logic signed [23:0] TEMP_MIN = -24'sh800000;
   localparam logic [25:0]        PRES_MAX = 26'h3FFFFFF;

   typedef struct packed {
      logic [23:0] raw_pressure;
      logic [23:0] raw_temperature;
   } req_type;

   typedef struct packed {
      logic signed [23:0] temperature_q16;
      logic [25:0]        pressure_q8;
      logic               status;
   } rsp_type;

   typedef struct packed {
      logic [15:0]        t1;
      logic [15:0]        t2;
      logic signed [7:0]  t3;
      logic signed [16:0] p1;
      logic signed [16:0] p2;
      logic signed [7:0]  p3;
      logic signed [7:0]  p4;
      logic [15:0]        p5;
      logic [15:0]        p6;
      logic signed [7:0]  p7;
      logic signed [7:0]  p8;
      logic signed [15:0] p9;
      logic signed [7:0]  p10;
      logic signed [7:0]  p11;
   } trim_type;
endpackage
`default_nettype wire

FILE: src/baro_pressure_temp_compensation.sv
// Barometric pressure and temperature compensation, top level.
//
// req_ carries one raw pressure / temperature pair per transaction; rsp_
// returns one compensated result per transaction, in order. A transaction
// is taken when valid is high and stall is low.
// csr_ writes the trim words and the calibrated flag (index 0..3); write
// only while no transaction is in flight. csr_ready is always high.
// Throughput: one transaction per cycle while rsp_stall does not hold the
// pipeline. There are nine compute stages (temperature difference, raw
// products, t, then three Horner steps in t, each a partial-product stage
// and a sum stage) plus the output register.
// Reset clears the pipeline valid bits and the trim registers; results
// then report status not calibrated until the flag is written.
// When the receiver stalls with a result pending, the whole pipeline holds
// and req_stall rises in the same cycle; nothing is dropped or repeated.
`default_nettype none
module baro_pressure_temp_compensation (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  bptc_pkg::req_type  req_data,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output bptc_pkg::rsp_type  rsp_data,
   input  wire                csr_valid,
   output logic               csr_ready,
   input  wire  [1:0]         csr_index,
   input  wire  [63:0]        csr_wdata
);
   import bptc_pkg::*;

   trim_type trim;
   logic     calibrated;

   bptc_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .trim       (trim),
      .calibrated (calibrated)
   );

   bptc_pipe u_pipe (
      .clock      (clock),
      .reset      (reset),
      .trim       (trim),
      .calibrated (calibrated),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_data   (req_data),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_data   (rsp_data)
   );
endmodule
`default_nettype wire

FILE: src/bptc_csr.sv
// Trim registers and coefficient unpacking.
`default_nettype none
module bptc_csr (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire  [1:0]          csr_index,
   input  wire  [63:0]         csr_wdata,
   output bptc_pkg::trim_type  trim,
   output logic                calibrated
);
   import bptc_pkg::*;

   logic [63:0]  low_ff, mid_ff;
   logic [39:0]  high_ff;
   logic         cal_ff;
   logic [167:0] b;

   assign csr_ready  = 1'b1;
   assign calibrated = cal_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff  <= '0;
         mid_ff  <= '0;
         high_ff <= '0;
         cal_ff  <= 1'b0;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_TRIM_LOW:  low_ff  <= csr_wdata;
            CSR_TRIM_MID:  mid_ff  <= csr_wdata;
            CSR_TRIM_HIGH: high_ff <= csr_wdata[39:0];
            CSR_CAL:       cal_ff  <= csr_wdata[0];
            default:       cal_ff  <= cal_ff;
         endcase
      end
   end

   always_comb begin
      b        = {high_ff, mid_ff, low_ff};
      trim.t1  = b[15:0];
      trim.t2  = b[31:16];
      trim.t3  = b[39:32];
      // remove the factory offset of the two leading pressure terms
      trim.p1  = 17'($signed(b[55:40])) - 17'sd16384;
      trim.p2  = 17'($signed(b[71:56])) - 17'sd16384;
      trim.p3  = b[79:72];
      trim.p4  = b[87:80];
      trim.p5  = b[103:88];
      trim.p6  = b[119:104];
      trim.p7  = b[127:120];
      trim.p8  = b[135:128];
      trim.p9  = b[151:136];
      trim.p10 = b[159:152];
      trim.p11 = b[167:160];
   end
endmodule
`default_nettype wire

FILE: src/bptc_pipe.sv
// Compensation pipeline: temperature, then Horner evaluation of pressure in t.
`default_nettype none
module bptc_pipe (
   input  wire                 clock,
   input  wire                 reset,
   input  bptc_pkg::trim_type  trim,
   input  wire                 calibrated,
   input  wire                 req_valid,
   output logic                req_stall,
   input  bptc_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output bptc_pkg::rsp_type   rsp_data
);
   import bptc_pkg::*;

   logic        adv;
   logic [8:0]  v_ff;
   logic [8:0]  cal_ff;
   logic        rsp_valid_ff;
   rsp_type     rsp_ff, rsp_in;

   // stage 1: temperature difference
   logic [23:0]        p1_ff;
   logic signed [25:0] d1_ff, d1_in;
   // stage 2: raw products
   logic [23:0]        p2_ff;
   logic [47:0]        pp2_ff, pp2_in;
   logic signed [42:0] dt2_ff, dt2_in;
   logic signed [49:0] dd2_ff, dd2_in;
   // stage 3: t and the innermost Horner coefficient
   logic [23:0]        p3_ff;
   logic [47:0]        pp3_ff;
   logic [71:0]        ppp3_ff, ppp3_in;
   logic signed [63:0] nt3_ff, nt3_in;
   logic signed [39:0] a3_ff, a3_in;
   // stage 4: partial products of t * a3, temperature output
   logic [23:0]        p4_ff;
   logic [47:0]        pp4_ff;
   logic [71:0]        ppp4_ff;
   logic signed [63:0] nt4_ff, v4;
   logic signed [23:0] tq4_ff, tq4_in;
   logic signed [95:0] a2_ff, a2_in;
   logic signed [32:0] n4 [0:1];
   logic signed [32:0] x4 [0:1];
   logic signed [65:0] m4_ff [0:1][0:1];
   logic signed [65:0] m4_in [0:1][0:1];
   // stage 5: h2 = a2 + t * a3
   logic [23:0]        p5_ff;
   logic [47:0]        pp5_ff;
   logic [71:0]        ppp5_ff;
   logic signed [63:0] nt5_ff;
   logic signed [23:0] tq5_ff;
   logic signed [95:0] h2_ff, h2_in;
   // stage 6: partial products of t * h2
   logic [23:0]         p6_ff;
   logic [47:0]         pp6_ff;
   logic [71:0]         ppp6_ff;
   logic signed [63:0]  nt6_ff;
   logic signed [23:0]  tq6_ff;
   logic signed [159:0] a1_ff, a1_in;
   logic signed [32:0]  n6 [0:1];
   logic signed [32:0]  x6 [0:2];
   logic signed [65:0]  m6_ff [0:1][0:2];
   logic signed [65:0]  m6_in [0:1][0:2];
   // stage 7: h1 = a1 + t * h2
   logic [23:0]         p7_ff;
   logic [47:0]         pp7_ff;
   logic [71:0]         ppp7_ff;
   logic signed [63:0]  nt7_ff;
   logic signed [23:0]  tq7_ff;
   logic signed [159:0] h1_ff, h1_in;
   // stage 8: partial products of t * h1
   logic signed [23:0]  tq8_ff;
   logic signed [255:0] a0_ff, a0_in;
   logic signed [32:0]  n8 [0:1];
   logic signed [32:0]  x8 [0:4];
   logic signed [65:0]  m8_ff [0:1][0:4];
   logic signed [65:0]  m8_in [0:1][0:4];
   // stage 9: np = a0 + t * h1
   logic signed [23:0]  tq9_ff;
   logic signed [255:0] np_ff, np_in;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !adv;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff         <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v_ff         <= {v_ff[7:0], req_valid};
         rsp_valid_ff <= v_ff[8];
      end
   end

   always_comb begin
      d1_in = $signed({2'b00, req_data.raw_temperature}) - $signed({2'b00, trim.t1, 8'h00});
   end

   always_comb begin
      dt2_in = 43'(d1_ff) * 43'($signed({1'b0, trim.t2}));
      dd2_in = 50'(d1_ff) * 50'(d1_ff);
      pp2_in = 48'(p1_ff) * 48'(p1_ff);
   end

   always_comb begin
      nt3_in  = (64'(dt2_ff) <<< 18) + 64'(dd2_ff) * 64'(trim.t3);
      // split the cube so that each multiply stays 24 by 24
      ppp3_in = ((72'(pp2_ff[47:24]) * 72'(p2_ff)) << 24) + 72'(pp2_ff[23:0]) * 72'(p2_ff);
      a3_in   = (40'(trim.p8) <<< 22) + 40'(trim.p4) * 40'($signed({1'b0, p2_ff}));
   end

   always_comb begin
      v4 = nt3_ff + 64'sd2147483648;
      if (v4 >= (64'sd1 <<< 55)) tq4_in = TEMP_MAX;
      else if (v4 < -(64'sd1 <<< 55)) tq4_in = TEMP_MIN;
      else tq4_in = v4[55:32];
   end

   // low limbs are unsigned, the top limb carries the sign
   always_comb begin
      n4[0] = $signed({1'b0, nt3_ff[31:0]});
      n4[1] = $signed({nt3_ff[63], nt3_ff[63:32]});
      x4[0] = $signed({1'b0, a3_ff[31:0]});
      x4[1] = 33'($signed(a3_ff[39:32]));
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            m4_in[i][j] = 66'(n4[i]) * 66'(x4[j]);
      a2_in = (96'(trim.p7) <<< 77) + ((96'(trim.p3) * 96'($signed({1'b0, p3_ff}))) <<< 53);
   end

   always_comb begin
      h2_in = a2_ff;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 2; j++)
            h2_in = h2_in + (96'(m4_ff[i][j]) <<< (32 * (i + j)));
   end

   always_comb begin
      n6[0] = $signed({1'b0, nt5_ff[31:0]});
      n6[1] = $signed({nt5_ff[63], nt5_ff[63:32]});
      for (int j = 0; j < 2; j++)
         x6[j] = $signed({1'b0, h2_ff[32*j +: 32]});
      x6[2] = $signed({h2_ff[95], h2_ff[95:64]});
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 3; j++)
            m6_in[i][j] = 66'(n6[i]) * 66'(x6[j]);
      a1_in = (160'($signed({1'b0, trim.p6})) <<< 127)
            + ((160'(trim.p2) * 160'($signed({1'b0, p5_ff}))) <<< 104)
            + ((160'(trim.p10) * 160'($signed({1'b0, pp5_ff}))) <<< 85);
   end

   always_comb begin
      h1_in = a1_ff;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 3; j++)
            h1_in = h1_in + (160'(m6_ff[i][j]) <<< (32 * (i + j)));
   end

   always_comb begin
      n8[0] = $signed({1'b0, nt7_ff[31:0]});
      n8[1] = $signed({nt7_ff[63], nt7_ff[63:32]});
      for (int j = 0; j < 4; j++)
         x8[j] = $signed({1'b0, h1_ff[32*j +: 32]});
      x8[4] = $signed({h1_ff[159], h1_ff[159:128]});
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 5; j++)
            m8_in[i][j] = 66'(n8[i]) * 66'(x8[j]);
      // constant term also carries the rounding half
      a0_in = (256'($signed({1'b0, trim.p5})) <<< 184)
            + ((256'(trim.p1) * 256'($signed({1'b0, p7_ff}))) <<< 161)
            + ((256'(trim.p9) * 256'($signed({1'b0, pp7_ff}))) <<< 133)
            + ((256'(trim.p11) * 256'($signed({1'b0, ppp7_ff}))) <<< 116)
            + (256'sd1 <<< 172);
   end

   always_comb begin
      np_in = a0_ff;
      for (int i = 0; i < 2; i++)
         for (int j = 0; j < 5; j++)
            np_in = np_in + (256'(m8_ff[i][j]) <<< (32 * (i + j)));
   end

   always_comb begin
      rsp_in.temperature_q16 = tq9_ff;
      rsp_in.status          = 1'b0;
      if (np_ff[255]) rsp_in.pressure_q8 = '0;
      else if (|np_ff[254:199]) rsp_in.pressure_q8 = PRES_MAX;
      else rsp_in.pressure_q8 = np_ff[198:173];
      if (!cal_ff[8]) begin
         rsp_in.temperature_q16 = '0;
         rsp_in.pressure_q8     = '0;
         rsp_in.status          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cal_ff  <= {cal_ff[7:0], calibrated};
         p1_ff   <= req_data.raw_pressure;
         d1_ff   <= d1_in;
         p2_ff   <= p1_ff;
         pp2_ff  <= pp2_in;
         dt2_ff  <= dt2_in;
         dd2_ff  <= dd2_in;
         p3_ff   <= p2_ff;
         pp3_ff  <= pp2_ff;
         ppp3_ff <= ppp3_in;
         nt3_ff  <= nt3_in;
         a3_ff   <= a3_in;
         p4_ff   <= p3_ff;
         pp4_ff  <= pp3_ff;
         ppp4_ff <= ppp3_ff;
         nt4_ff  <= nt3_ff;
         tq4_ff  <= tq4_in;
         a2_ff   <= a2_in;
         m4_ff   <= m4_in;
         p5_ff   <= p4_ff;
         pp5_ff  <= pp4_ff;
         ppp5_ff <= ppp4_ff;
         nt5_ff  <= nt4_ff;
         tq5_ff  <= tq4_ff;
         h2_ff   <= h2_in;
         p6_ff   <= p5_ff;
         pp6_ff  <= pp5_ff;
         ppp6_ff <= ppp5_ff;
         nt6_ff  <= nt5_ff;
         tq6_ff  <= tq5_ff;
         a1_ff   <= a1_in;
         m6_ff   <= m6_in;
         p7_ff   <= p6_ff;
         pp7_ff  <= pp6_ff;
         ppp7_ff <= ppp6_ff;
         nt7_ff  <= nt6_ff;
         tq7_ff  <= tq6_ff;
         h1_ff   <= h1_in;
         tq8_ff  <= tq7_ff;
         a0_ff   <= a0_in;
         m8_ff   <= m8_in;
         tq9_ff  <= tq8_ff;
         np_ff   <= np_in;
         rsp_ff  <= rsp_in;
      end
   end
endmodule
`default_nettype wire

FILE: src/bptc_checker.sv
// Port-level checks for the compensation block, bound to the top level.
`default_nettype none
module bptc_checker (
   input wire                clock,
   input wire                reset,
   input wire                req_stall,
   input wire                rsp_valid,
   input wire                rsp_stall,
   input bptc_pkg::rsp_type  rsp_data
);
   import bptc_pkg::*;

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled transaction changed");

   a_uncal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status |->
         rsp_data.temperature_q16 == 24'sd0 && rsp_data.pressure_q8 == 26'd0)
      else $error("uncalibrated result not zero");

   a_reset: assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   a_backp: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without output backpressure");
endmodule

bind baro_pressure_temp_compensation bptc_checker u_bptc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
`default_nettype wire
